// ----- design/differential_drive_pose_update_top_defines.svh -----
// ----------------------------------------------------------------------------
// Pose update assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_POSE_UPDATE_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_POSE_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define DDPU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDPU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ddpu_pkg.sv -----
// ----------------------------------------------------------------------------
// Pose update package
// Widths, constants, tables and shared types of the pose update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddpu_pkg;

	localparam int POS_FRAC_BITS = 8;
	localparam int ANGLE_BITS    = 16;
	localparam int POS_BITS      = 12 + POS_FRAC_BITS;
	localparam int NX_W          = POS_BITS + 2;

	localparam int ARENA_W = 13;
	localparam logic [ARENA_W-1:0] ARENA_MAX = 13'd4096;

	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int ZW           = 18;
	localparam int TRIG_W       = 17;
	localparam int ROUND_SH     = 16;
	localparam int CRD_W        = ROUND_SH + TRIG_W;
	localparam logic signed [CRD_W-1:0] CORDIC_K = 33'sd652032874;

	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SPLIT   = 25;
	localparam int ACC_W   = MUL_P_W + SPLIT;

	localparam int POS_SHIFT = 53 - POS_FRAC_BITS;
	localparam int ANG_SHIFT = 46 - ANGLE_BITS;

	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
		18'sd41,   18'sd20,   18'sd10,   18'sd5,    18'sd3,   18'sd1,   18'sd1,   18'sd0
	};

	typedef enum logic [1:0] {
		REG_ARENA_WIDTH  = 2'd0,
		REG_ARENA_HEIGHT = 2'd1,
		REG_FORWARD_GAIN = 2'd2,
		REG_TURN_GAIN    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} cordic_res_t;

	function automatic logic [15:0] heading16(input logic [ANGLE_BITS-1:0] h);
		logic [ANGLE_BITS+15:0] e;
		e = {h, 16'b0};
		return e[ANGLE_BITS+15 -: 16];
	endfunction

endpackage

// ----- design/ddpu_mul.sv -----
// ----------------------------------------------------------------------------
// Pose update multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddpu_mul
	import ddpu_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- design/ddpu_cordic.sv -----
// ----------------------------------------------------------------------------
// Pose update CORDIC
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddpu_cordic
	import ddpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] angle,
	output cordic_res_t res
);

	logic                    busy_q;
	logic                    fin_q;
	logic [ITER_W-1:0]       iter_q;
	logic signed [CRD_W-1:0] x_q;
	logic signed [CRD_W-1:0] y_q;
	logic signed [ZW-1:0]    z_q;
	logic                    flip_q;
	logic                    done_q;
	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;

	logic signed [16:0]      a_ext;
	logic signed [16:0]      a_fold;
	logic                    fold;
	logic signed [CRD_W-1:0] xs, ys, nx, ny, xf, yf, xr, yr;
	logic signed [ZW-1:0]    nz;

	always_comb begin
		a_ext  = 17'($signed(angle));
		a_fold = a_ext;
		fold   = 1'b0;
		if (a_ext > 17'sd16384) begin
			a_fold = a_ext - 17'sd32768;
			fold   = 1'b1;
		end else if (a_ext < -17'sd16384) begin
			a_fold = a_ext + 17'sd32768;
			fold   = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		if (!z_q[ZW-1]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - ATAN_TAB[iter_q];
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + ATAN_TAB[iter_q];
		end
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xr = xf + (CRD_W'(1) <<< (ROUND_SH - 1));
		yr = yf + (CRD_W'(1) <<< (ROUND_SH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_K;
			y_q    <= '0;
			z_q    <= ZW'(a_fold);
			flip_q <= fold;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
		if (fin_q) begin
			cos_q <= xr[ROUND_SH +: TRIG_W];
			sin_q <= yr[ROUND_SH +: TRIG_W];
		end
	end

	assign res = '{done: done_q, cos_v: cos_q, sin_v: sin_q};

endmodule

// ----- design/differential_drive_pose_update_top.sv -----
// ----------------------------------------------------------------------------
// Differential drive pose update
// Euler-step odometry: moves a clamped position along the heading and
// advances the heading from left and right wheel speeds.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   request  | in        | in_valid/in_stall  | vel_left vel_right time_step
//   result   | out       | out_valid/out_stall| pos_x pos_y heading
//   config   | in        | cfg_we             | cfg_index cfg_data
//
// A request passes from acceptance through the 16-iteration CORDIC and its
// rounding, then 12 slots of the shared multiplier for the distance, heading
// and position steps, and its result is then loaded into the output register.
// in_stall is high while a request is at work; a waiting result is held in
// the output register, and the next request finishes only once it is taken.
// Reset is asynchronous and leaves the pose at the origin facing positive x.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_pose_update_top
	import ddpu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] vel_left,
	input  logic signed [15:0] vel_right,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [19:0]        pos_x,
	output logic [19:0]        pos_y,
	output logic signed [15:0] heading
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		MS_FWD_GAIN,
		MS_TURN_GAIN,
		MS_DIST,
		MS_TURN,
		MS_COS_HI,
		MS_COS_LO,
		MS_SIN_HI,
		MS_SIN_LO,
		MS_ACC_Y,
		MS_CLAMP_X,
		MS_SUB_Y,
		MS_CLAMP_Y
	} mul_step_t;

	state_t                    state_q;
	mul_step_t                 step_q;

	logic [ARENA_W-1:0]        arena_w_q;
	logic [ARENA_W-1:0]        arena_h_q;
	logic [15:0]               fwd_gain_q;
	logic [15:0]               turn_gain_q;

	logic [POS_BITS-1:0]       x_q;
	logic [POS_BITS-1:0]       y_q;
	logic [ANGLE_BITS-1:0]     heading_q;

	logic signed [15:0]        l_q;
	logic signed [15:0]        r_q;
	logic [15:0]               dt_q;
	logic signed [MUL_A_W-1:0] pf_q;
	logic signed [MUL_A_W-1:0] pt_q;
	logic signed [MUL_P_W-1:0] d_q;
	logic signed [MUL_P_W-1:0] ph_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [NX_W-1:0]    dx_q;
	logic signed [NX_W-1:0]    nx_q;

	logic                      out_valid_q;
	logic [19:0]               pos_x_q;
	logic [19:0]               pos_y_q;
	logic [15:0]               heading_out_q;

	logic                      in_accept;
	logic                      in_mul;
	logic                      out_free;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	cordic_res_t               trig;

	logic signed [16:0]        sum_lr;
	logic signed [16:0]        dif_rl;
	logic signed [MUL_A_W-1:0] d_hi;
	logic signed [MUL_A_W-1:0] d_lo;
	logic signed [MUL_B_W-1:0] dt_ext;
	logic signed [ACC_W-1:0]   acc_new;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [MUL_P_W-1:0] ht_rnd;
	logic [POS_BITS+19:0]      x_ext;
	logic [POS_BITS+19:0]      y_ext;

	function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [NX_W-1:0] p,
			input logic [ARENA_W-1:0] size);
		logic [ARENA_W-1:0]     sz;
		logic signed [NX_W-1:0] lim;
		sz = size;
		if (sz == '0) begin
			sz = ARENA_W'(1);
		end else if (sz > ARENA_MAX) begin
			sz = ARENA_MAX;
		end
		lim = NX_W'($signed({1'b0, sz, {POS_FRAC_BITS{1'b0}}}));
		if (p < 0) begin
			return '0;
		end else if (p >= lim) begin
			return POS_BITS'({sz - ARENA_W'(1), {POS_FRAC_BITS{1'b0}}});
		end
		return p[POS_BITS-1:0];
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign in_mul    = (state_q == ST_MUL);
	assign out_free  = !out_valid_q || !out_stall;

	ddpu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.angle  (heading16(heading_q)),
		.res    (trig)
	);

	ddpu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// operand selection for the shared multiplier
	always_comb begin
		sum_lr = 17'(l_q) + 17'(r_q);
		dif_rl = 17'(r_q) - 17'(l_q);
		d_hi   = MUL_A_W'(d_q >>> SPLIT);
		d_lo   = MUL_A_W'($signed({1'b0, d_q[SPLIT-1:0]}));
		dt_ext = MUL_B_W'($signed({1'b0, dt_q}));
		mul_a  = '0;
		mul_b  = '0;
		case (step_q)
			MS_FWD_GAIN: begin
				mul_a = MUL_A_W'($signed({1'b0, fwd_gain_q}));
				mul_b = MUL_B_W'(sum_lr);
			end
			MS_TURN_GAIN: begin
				mul_a = MUL_A_W'($signed({1'b0, turn_gain_q}));
				mul_b = MUL_B_W'(dif_rl);
			end
			MS_DIST: begin
				mul_a = pf_q;
				mul_b = dt_ext;
			end
			MS_TURN: begin
				mul_a = pt_q;
				mul_b = dt_ext;
			end
			MS_COS_HI: begin
				mul_a = d_hi;
				mul_b = MUL_B_W'($signed(trig.cos_v));
			end
			MS_COS_LO: begin
				mul_a = d_lo;
				mul_b = MUL_B_W'($signed(trig.cos_v));
			end
			MS_SIN_HI: begin
				mul_a = d_hi;
				mul_b = MUL_B_W'($signed(trig.sin_v));
			end
			MS_SIN_LO: begin
				mul_a = d_lo;
				mul_b = MUL_B_W'($signed(trig.sin_v));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		acc_new = (ACC_W'(ph_q) <<< SPLIT) + ACC_W'(mul_p);
		acc_rnd = acc_q + (ACC_W'(1) <<< (POS_SHIFT - 1));
		ht_rnd  = mul_p + (MUL_P_W'(1) <<< (ANG_SHIFT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_w_q   <= ARENA_MAX;
			arena_h_q   <= ARENA_MAX;
			fwd_gain_q  <= 16'd25600;
			turn_gain_q <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ARENA_WIDTH:  arena_w_q   <= cfg_data[ARENA_W-1:0];
				REG_ARENA_HEIGHT: arena_h_q   <= cfg_data[ARENA_W-1:0];
				REG_FORWARD_GAIN: fwd_gain_q  <= cfg_data;
				REG_TURN_GAIN:    turn_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else if (in_mul) begin
			case (step_q)
				MS_COS_HI:  heading_q <= heading_q + ht_rnd[ANG_SHIFT +: ANGLE_BITS];
				MS_CLAMP_X: x_q <= clamp_pos(nx_q, arena_w_q);
				MS_CLAMP_Y: y_q <= clamp_pos(nx_q, arena_h_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			l_q  <= vel_left;
			r_q  <= vel_right;
			dt_q <= time_step;
		end
		if (in_mul) begin
			case (step_q)
				MS_TURN_GAIN: pf_q <= MUL_A_W'(mul_p);
				MS_DIST:      pt_q <= MUL_A_W'(mul_p);
				MS_TURN:      d_q  <= mul_p;
				MS_COS_LO:    ph_q <= mul_p;
				MS_SIN_HI:    acc_q <= acc_new;
				MS_SIN_LO: begin
					ph_q <= mul_p;
					dx_q <= acc_rnd[POS_SHIFT +: NX_W];
				end
				MS_ACC_Y: begin
					acc_q <= acc_new;
					nx_q  <= NX_W'($signed({1'b0, x_q})) + dx_q;
				end
				MS_CLAMP_X:   dx_q <= acc_rnd[POS_SHIFT +: NX_W];
				MS_SUB_Y:     nx_q <= NX_W'($signed({1'b0, y_q})) - dx_q;
				default: ;
			endcase
		end
	end

	assign x_ext = {20'b0, x_q};
	assign y_ext = {20'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= MS_FWD_GAIN;
			out_valid_q   <= 1'b0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			heading_out_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (trig.done) begin
						state_q <= ST_MUL;
						step_q  <= MS_FWD_GAIN;
					end
				end
				ST_MUL: begin
					if (step_q == MS_CLAMP_Y) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= mul_step_t'(step_q + 1'b1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						pos_x_q       <= x_ext[19:0];
						pos_y_q       <= y_ext[19:0];
						heading_out_q <= heading16(heading_q);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = $signed(heading_out_q);

endmodule

// ----- design/ddpu_checker.sv -----
// ----------------------------------------------------------------------------
// Pose update checker
// Port-level assertions on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "differential_drive_pose_update_top_defines.svh"

module ddpu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [19:0]        pos_x,
	input logic [19:0]        pos_y,
	input logic signed [15:0] heading
);

	`DDPU_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request accepted while not busy afterwards")
	`DDPU_ASSERT_IMP(a_result_ends_busy, $rose(out_valid), $fell(in_stall), "result appeared without ending a request")
	`DDPU_ASSERT_NXT(a_out_valid_holds, out_valid && out_stall, out_valid, "stalled result dropped")
	`DDPU_ASSERT_NXT(a_out_payload_holds, out_valid && out_stall, $stable(pos_x) && $stable(pos_y) && $stable(heading), "stalled result changed")

endmodule

bind differential_drive_pose_update_top ddpu_checker u_ddpu_checker (.*);
